// ===== hw/rtl/nmp_pkg.sv =====
// Shared types and constants for the NoC message packetiser.
// No dependencies; imported by every module of the block.
package nmp_pkg;

    localparam int FLIT_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int CPU_W          = 8;
    localparam int MESH_W         = 5;
    localparam int COUNT_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int HDR_FLITS      = 8;
    localparam int HDR_IDX_W      = 3;
    localparam int DIV_STEPS      = CPU_W;
    localparam int PACKET_FLITS_DEF = 64;

    localparam logic [FLIT_W-1:0] PAD_WORD = 16'hdead;

    localparam logic [CFG_IDX_W-1:0] CFG_CPU_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_WIDTH = 2'd2;

    localparam logic [MESH_W-1:0] MESH_WIDTH_RST = 5'd2;

    localparam logic [HDR_IDX_W-1:0] HDR_TARGET  = 3'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_LENGTH  = 3'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_SRC_CPU = 3'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_SRC_PRT = 3'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_TGT_PRT = 3'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_SIZE    = 3'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_SEQ     = 3'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_CHANNEL = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_HDR,
        ST_BYTE,
        ST_PAD
    } nmp_state_t;

    typedef enum logic [1:0] {
        SEL_HDR,
        SEL_PAY,
        SEL_PAD
    } nmp_sel_t;

    typedef struct packed {
        logic                 load;
        logic                 div_step;
        logic                 hold;
        logic                 emit;
        nmp_sel_t             sel;
        logic [HDR_IDX_W-1:0] hdr_idx;
    } nmp_cmd_t;

    typedef struct packed {
        logic pkt_start;
        logic odd_mid;
        logic ends;
        logic last;
        logic room;
    } nmp_status_t;

endpackage

// ===== hw/rtl/noc_message_packetizer_unit.sv =====
// NoC message packetiser top level: controller plus datapath.
// Depends on nmp_pkg, nmp_ctrl and nmp_datapath.
//
//   channel   direction  handshake            word
//   in        to block   in_valid / in_stall  dest_cpu, dest_port, channel,
//                                             msg_len, data_byte
//   out       from block out_valid/out_stall  flit, last_flit
//   cfg       to block   cfg_we               cfg_index, cfg_data
//
// A byte that does not open a packet is accepted, then handled in a payload step.
// A byte that opens a packet runs the bit-serial target divider, then emits 8 header
// flits, one per cycle while the output is not stalled. The final byte adds padding.
// Reset is asynchronous, active low; it clears message state, mesh width to 2.
// Output stalls hold the output register and pause header, payload and padding flits.
module noc_message_packetizer_unit #(
    parameter int PACKET_FLITS = nmp_pkg::PACKET_FLITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nmp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [nmp_pkg::CPU_W-1:0]      dest_cpu,
    input  logic [nmp_pkg::FLIT_W-1:0]     dest_port,
    input  logic [nmp_pkg::FLIT_W-1:0]     channel,
    input  logic [nmp_pkg::COUNT_W-1:0]    msg_len,
    input  logic [nmp_pkg::BYTE_W-1:0]     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [nmp_pkg::FLIT_W-1:0]     flit,
    output logic                           last_flit
);
    import nmp_pkg::*;

    nmp_cmd_t    cmd;
    nmp_status_t status;

    nmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    nmp_datapath #(
        .PACKET_FLITS (PACKET_FLITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .dest_cpu    (dest_cpu),
        .dest_port   (dest_port),
        .channel     (channel),
        .msg_len     (msg_len),
        .data_byte   (data_byte),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .flit        (flit),
        .last_flit   (last_flit)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.hold, cmd.emit}))
        else $error("conflicting datapath commands");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.room)
        else $error("flit loaded over an untaken word");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.sel != SEL_HDR && status.last) |=> status.pkt_start)
        else $error("packet index not cleared after last flit");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word taken before the first was processed");

endmodule

// ===== hw/rtl/nmp_ctrl.sv =====
// Packetiser controller: sequences divide, header, payload and padding.
// Depends on nmp_pkg; drives nmp_datapath through command/status structs.
module nmp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nmp_pkg::nmp_status_t status,
    output nmp_pkg::nmp_cmd_t    cmd
);
    import nmp_pkg::*;

    nmp_state_t           state_reg;
    nmp_state_t           state_next;
    logic [HDR_IDX_W-1:0] step_reg;
    logic [HDR_IDX_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = status.pkt_start ? ST_DIV : ST_BYTE;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == HDR_IDX_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (status.room)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == HDR_IDX_W'(HDR_FLITS - 1))
                    begin
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_BYTE:
            begin
                if (status.odd_mid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.room)
                begin
                    state_next = (status.ends && !status.last) ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (status.room && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = SEL_HDR;
        cmd.hdr_idx  = step_reg;
        in_stall     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_HDR:
            begin
                cmd.emit = status.room;
            end
            ST_BYTE:
            begin
                cmd.sel  = SEL_PAY;
                cmd.hold = status.odd_mid;
                cmd.emit = !status.odd_mid && status.room;
            end
            ST_PAD:
            begin
                cmd.sel  = SEL_PAD;
                cmd.emit = status.room;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/nmp_datapath.sv =====
// Packetiser datapath: config registers, message state, target divider, output word.
// Depends on nmp_pkg; commanded by nmp_ctrl.
module nmp_datapath #(
    parameter int PACKET_FLITS = nmp_pkg::PACKET_FLITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [nmp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nmp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [nmp_pkg::CPU_W-1:0]        dest_cpu,
    input  logic [nmp_pkg::FLIT_W-1:0]       dest_port,
    input  logic [nmp_pkg::FLIT_W-1:0]       channel,
    input  logic [nmp_pkg::COUNT_W-1:0]      msg_len,
    input  logic [nmp_pkg::BYTE_W-1:0]       data_byte,
    input  logic                             out_stall,
    input  nmp_pkg::nmp_cmd_t                cmd,
    output nmp_pkg::nmp_status_t             status,
    output logic                             out_valid,
    output logic [nmp_pkg::FLIT_W-1:0]       flit,
    output logic                             last_flit
);
    import nmp_pkg::*;

    localparam int FI_W = $clog2(PACKET_FLITS + 1);

    logic [FLIT_W-1:0]  cpu_id_reg;
    logic [FLIT_W-1:0]  own_port_reg;
    logic [MESH_W-1:0]  mesh_width_reg;

    logic [COUNT_W-1:0] byte_count_reg;
    logic [FI_W-1:0]    flit_index_reg;
    logic [BYTE_W-1:0]  held_byte_reg;
    logic [COUNT_W-1:0] packet_seq_reg;
    logic               out_valid_reg;

    logic [FLIT_W-1:0]  tport_reg;
    logic [FLIT_W-1:0]  chan_reg;
    logic [COUNT_W-1:0] msize_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [MESH_W-1:0]  rem_reg;
    logic [CPU_W-1:0]   quo_reg;
    logic [FLIT_W-1:0]  flit_reg;
    logic               last_reg;

    logic [MESH_W-1:0]  divisor;
    logic [MESH_W:0]    trial;
    logic               fits;
    logic [MESH_W-1:0]  rem_step;
    logic [COUNT_W:0]   count;
    logic               ends;
    logic               odd;
    logic [FI_W-1:0]    fi_inc;
    logic               is_last;
    logic               room;
    logic [FLIT_W-1:0]  hdr_word;
    logic [FLIT_W-1:0]  pay_word;
    logic [FLIT_W-1:0]  word;

    assign divisor  = (mesh_width_reg == '0) ? MESH_W'(1) : mesh_width_reg;
    assign trial    = {rem_reg, quo_reg[CPU_W-1]};
    assign fits     = trial >= {1'b0, divisor};
    assign rem_step = fits ? MESH_W'(trial - {1'b0, divisor}) : trial[MESH_W-1:0];

    assign count   = {1'b0, byte_count_reg} + (COUNT_W+1)'(1);
    assign ends    = count >= {1'b0, msize_reg};
    assign odd     = count[0];
    assign fi_inc  = flit_index_reg + 1'b1;
    assign is_last = fi_inc >= FI_W'(PACKET_FLITS);
    assign room    = !out_valid_reg || !out_stall;

    assign status.pkt_start = (flit_index_reg == '0);
    assign status.odd_mid   = odd && !ends;
    assign status.ends      = ends;
    assign status.last      = is_last;
    assign status.room      = room;

    always_comb
    begin
        case (cmd.hdr_idx)
            HDR_TARGET:  hdr_word = {7'd0, rem_reg, 4'd0} | {8'd0, quo_reg};
            HDR_LENGTH:  hdr_word = FLIT_W'(PACKET_FLITS - 2);
            HDR_SRC_CPU: hdr_word = cpu_id_reg;
            HDR_SRC_PRT: hdr_word = own_port_reg;
            HDR_TGT_PRT: hdr_word = tport_reg;
            HDR_SIZE:    hdr_word = msize_reg;
            HDR_SEQ:     hdr_word = packet_seq_reg;
            HDR_CHANNEL: hdr_word = chan_reg;
            default:     hdr_word = chan_reg;
        endcase
    end

    assign pay_word = odd ? {data_reg, 8'h00} : {held_byte_reg, data_reg};

    always_comb
    begin
        case (cmd.sel)
            SEL_HDR: word = hdr_word;
            SEL_PAY: word = pay_word;
            SEL_PAD: word = PAD_WORD;
            default: word = PAD_WORD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_id_reg     <= '0;
            own_port_reg   <= '0;
            mesh_width_reg <= MESH_WIDTH_RST;
            byte_count_reg <= '0;
            flit_index_reg <= '0;
            held_byte_reg  <= '0;
            packet_seq_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CPU_ID:     cpu_id_reg     <= cfg_data;
                    CFG_OWN_PORT:   own_port_reg   <= cfg_data;
                    CFG_MESH_WIDTH: mesh_width_reg <= cfg_data[MESH_W-1:0];
                    default:        ;
                endcase
            end

            if (cmd.load && status.pkt_start)
            begin
                packet_seq_reg <= packet_seq_reg + 1'b1;
            end

            if (cmd.hold)
            begin
                byte_count_reg <= count[COUNT_W-1:0];
                held_byte_reg  <= data_reg;
            end

            if (cmd.emit)
            begin
                case (cmd.sel)
                    SEL_HDR:
                    begin
                        if (cmd.hdr_idx == HDR_CHANNEL)
                        begin
                            flit_index_reg <= FI_W'(HDR_FLITS);
                        end
                    end
                    SEL_PAY:
                    begin
                        if (ends && is_last)
                        begin
                            byte_count_reg <= '0;
                            flit_index_reg <= '0;
                            held_byte_reg  <= '0;
                            packet_seq_reg <= '0;
                        end
                        else if (ends)
                        begin
                            flit_index_reg <= fi_inc;
                        end
                        else
                        begin
                            byte_count_reg <= count[COUNT_W-1:0];
                            held_byte_reg  <= '0;
                            flit_index_reg <= is_last ? '0 : fi_inc;
                        end
                    end
                    SEL_PAD:
                    begin
                        if (is_last)
                        begin
                            byte_count_reg <= '0;
                            flit_index_reg <= '0;
                            held_byte_reg  <= '0;
                            packet_seq_reg <= '0;
                        end
                        else
                        begin
                            flit_index_reg <= fi_inc;
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tport_reg <= dest_port;
            chan_reg  <= channel;
            msize_reg <= msg_len;
            data_reg  <= data_byte;
            rem_reg   <= '0;
            quo_reg   <= dest_cpu;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[CPU_W-2:0], fits};
        end
        if (cmd.emit)
        begin
            flit_reg <= word;
            last_reg <= (cmd.sel != SEL_HDR) && is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign flit      = flit_reg;
    assign last_flit = last_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for noc_message_packetizer_unit: queued message bytes, flit predictor,
// in-order flit check under random idling and stalls. Depends on nmp_pkg and the RTL only.
module testbench;
    import nmp_pkg::*;

    localparam int PKT_FLITS      = PACKET_FLITS_DEF;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 50;

    typedef struct packed {
        logic [CPU_W-1:0]   dest_cpu;
        logic [FLIT_W-1:0]  dest_port;
        logic [FLIT_W-1:0]  channel;
        logic [COUNT_W-1:0] msg_len;
        logic [BYTE_W-1:0]  data_byte;
    } msg_byte_t;

    typedef struct packed {
        logic [FLIT_W-1:0] flit;
        logic              last;
    } flit_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CPU_W-1:0]      dest_cpu = '0;
    logic [FLIT_W-1:0]     dest_port = '0;
    logic [FLIT_W-1:0]     channel = '0;
    logic [COUNT_W-1:0]    msg_len = '0;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [FLIT_W-1:0]     flit;
    logic                  last_flit;

    noc_message_packetizer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .dest_cpu    (dest_cpu),
        .dest_port   (dest_port),
        .channel     (channel),
        .msg_len     (msg_len),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .flit        (flit),
        .last_flit   (last_flit)
    );

    msg_byte_t  byte_q[$];
    flit_word_t flit_q[$];
    msg_byte_t  cur_byte;
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         errors = 0;
    int         idle_cycles = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;

    // predictor copy of registers and message state
    logic [FLIT_W-1:0]  cpu_reg = '0;
    logic [FLIT_W-1:0]  port_reg = '0;
    logic [MESH_W-1:0]  mesh_reg = MESH_WIDTH_RST;
    logic [COUNT_W-1:0] msg_count = '0;
    int                 pkt_pos = 0;
    logic [BYTE_W-1:0]  held = '0;
    logic [FLIT_W-1:0]  pkt_seq = '0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic emit_flit(input logic [FLIT_W-1:0] f, input logic l);
        flit_word_t w;
        w.flit = f;
        w.last = l;
        flit_q.push_back(w);
    endtask

    task automatic packetize_byte(input msg_byte_t b);
        int unsigned cols;
        int unsigned col;
        int unsigned row;
        logic [COUNT_W:0] count;
        logic ends;
        if (pkt_pos == 0)
        begin
            cols = (mesh_reg == 0) ? 1 : mesh_reg;
            col = b.dest_cpu % cols;
            row = b.dest_cpu / cols;
            pkt_seq = pkt_seq + 1'b1;
            emit_flit(FLIT_W'((col << 4) | row), 1'b0);
            emit_flit(FLIT_W'(PKT_FLITS - 2), 1'b0);
            emit_flit(cpu_reg, 1'b0);
            emit_flit(port_reg, 1'b0);
            emit_flit(b.dest_port, 1'b0);
            emit_flit(b.msg_len, 1'b0);
            emit_flit(pkt_seq, 1'b0);
            emit_flit(b.channel, 1'b0);
            pkt_pos = HDR_FLITS;
        end
        count = {1'b0, msg_count} + 1'b1;
        ends = (count >= {1'b0, b.msg_len});
        if (count[0])
        begin
            if (!ends)
            begin
                held = b.data_byte;
                msg_count = count[COUNT_W-1:0];
                return;
            end
            pkt_pos++;
            emit_flit({b.data_byte, 8'h00}, pkt_pos >= PKT_FLITS);
        end
        else
        begin
            pkt_pos++;
            emit_flit({held, b.data_byte}, pkt_pos >= PKT_FLITS);
        end
        if (ends)
        begin
            while (pkt_pos < PKT_FLITS)
            begin
                pkt_pos++;
                emit_flit(PAD_WORD, pkt_pos >= PKT_FLITS);
            end
            msg_count = '0;
            pkt_pos = 0;
            held = '0;
            pkt_seq = '0;
            return;
        end
        msg_count = count[COUNT_W-1:0];
        held = '0;
        if (pkt_pos >= PKT_FLITS)
            pkt_pos = 0;
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                packetize_byte(cur_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    cur_byte = byte_q.pop_front();
                    dest_cpu <= cur_byte.dest_cpu;
                    dest_port <= cur_byte.dest_port;
                    channel <= cur_byte.channel;
                    msg_len <= cur_byte.msg_len;
                    data_byte <= cur_byte.data_byte;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // flit monitor
    always @(posedge clk)
    begin
        flit_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (flit_q.size() == 0)
            begin
                $display("%0t unexpected flit: got %h last %0b", $time, flit, last_flit);
                errors++;
            end
            else
            begin
                exp_w = flit_q.pop_front();
                if (flit !== exp_w.flit)
                begin
                    $display("%0t flit mismatch: expected %h, got %h",
                             $time, exp_w.flit, flit);
                    errors++;
                end
                if (last_flit !== exp_w.last)
                begin
                    $display("%0t last_flit mismatch: expected %0b, got %0b",
                             $time, exp_w.last, last_flit);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
                $display("[noc_message_packetizer_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [CPU_W-1:0] tcpu, input logic [FLIT_W-1:0] tport,
                             input logic [FLIT_W-1:0] chan, input logic [COUNT_W-1:0] size,
                             input logic [BYTE_W-1:0] data);
        msg_byte_t b;
        b.dest_cpu = tcpu;
        b.dest_port = tport;
        b.channel = chan;
        b.msg_len = size;
        b.data_byte = data;
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [FLIT_W-1:0] rand_channel();
        return ($urandom_range(0, 7) == 0) ? 16'hffff : FLIT_W'($urandom);
    endfunction

    task automatic queue_message(input int size, input bit vary_hdr);
        logic [CPU_W-1:0]  tcpu;
        logic [FLIT_W-1:0] tport;
        logic [FLIT_W-1:0] chan;
        tcpu = CPU_W'($urandom);
        tport = FLIT_W'($urandom);
        chan = rand_channel();
        for (int i = 0; i < size; i++)
        begin
            if (vary_hdr)
            begin
                tcpu = CPU_W'($urandom);
                tport = FLIT_W'($urandom);
                chan = rand_channel();
            end
            push_byte(tcpu, tport, chan, COUNT_W'(size), BYTE_W'($urandom));
        end
    endtask

    // size field drops below the bytes taken so far, closing the message early
    task automatic queue_cut_message(input int kept);
        logic [CPU_W-1:0]   tcpu;
        logic [FLIT_W-1:0]  tport;
        logic [FLIT_W-1:0]  chan;
        logic [COUNT_W-1:0] big;
        tcpu = CPU_W'($urandom);
        tport = FLIT_W'($urandom);
        chan = rand_channel();
        big = COUNT_W'($urandom_range(kept + 2, 65535));
        for (int i = 0; i < kept; i++)
            push_byte(tcpu, tport, chan, big, BYTE_W'($urandom));
        push_byte(tcpu, tport, chan, COUNT_W'($urandom_range(0, kept)), BYTE_W'($urandom));
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || flit_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CPU_ID:     cpu_reg = val;
            CFG_OWN_PORT:   port_reg = val;
            CFG_MESH_WIDTH: mesh_reg = val[MESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [15:0] cpu, input logic [15:0] port,
                             input logic [4:0] cols, input int tx_pct, input int rx_pct);
        int start;
        int pick;
        write_reg(CFG_CPU_ID, cpu);
        write_reg(CFG_OWN_PORT, port);
        write_reg(CFG_MESH_WIDTH, {11'd0, cols});
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        start = bytes_queued;
        while (bytes_queued - start < PHASE_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 56)
                queue_message($urandom_range(1, 20), 1'b0);
            else if (pick < 68)
                queue_message($urandom_range(21, 60), 1'b0);
            else if (pick < 76)
                queue_message($urandom_range(100, 130), 1'b0);
            else if (pick < 86)
                queue_message($urandom_range(1, 20), 1'b1);
            else
                queue_cut_message($urandom_range(1, 20));
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, no idling
        push_byte(8'd0, 16'h0000, 16'h0000, 16'd1, 8'hff);
        push_byte(8'd255, 16'hffff, 16'hffff, 16'd2, 8'h00);
        push_byte(8'd255, 16'hffff, 16'hffff, 16'd2, 8'hff);
        push_byte(8'd17, 16'h1234, 16'h0005, 16'd0, 8'h3c);
        push_byte(8'd9, 16'h8001, 16'hffff, 16'd3, 8'ha5);
        push_byte(8'd9, 16'h8001, 16'hffff, 16'd3, 8'h5a);
        push_byte(8'd9, 16'h8001, 16'hffff, 16'd3, 8'h80);
        push_byte(8'd200, 16'h00ff, 16'h7fff, 16'hffff, 8'h01);
        push_byte(8'd200, 16'h00ff, 16'h7fff, 16'hffff, 8'h02);
        push_byte(8'd200, 16'h00ff, 16'h7fff, 16'hffff, 8'h04);
        push_byte(8'd200, 16'h00ff, 16'h7fff, 16'd2, 8'h08);
        push_byte(8'd128, 16'hff00, 16'h8000, 16'hffff, 8'h10);
        push_byte(8'd128, 16'hff00, 16'h8000, 16'hffff, 8'h20);
        push_byte(8'd128, 16'hff00, 16'h8000, 16'd1, 8'h40);
        // header fields come from the word that opens the packet
        push_byte(8'd77, 16'h5555, 16'haaaa, 16'd2, 8'hc3);
        push_byte(8'd33, 16'haaaa, 16'h5555, 16'd2, 8'h3c);
        wait_drained();

        run_phase(16'hffff, 16'hffff, 5'd1, 0, 0);
        run_phase(FLIT_W'($urandom), FLIT_W'($urandom), 5'd16, 56, 0);
        run_phase(16'h0000, 16'h0000, 5'd0, 0, 56);
        run_phase(FLIT_W'($urandom), FLIT_W'($urandom), 5'($urandom_range(1, 16)), 36, 36);
        run_phase(FLIT_W'($urandom), FLIT_W'($urandom), 5'd3, 36, 36);

        if (flit_q.size() != 0)
        begin
            $display("%0t %0d expected flits never arrived", $time, flit_q.size());
            errors++;
        end
        if (errors == 0)
            $display("[noc_message_packetizer_unit] OK");
        else
            $display("[noc_message_packetizer_unit] ERROR");
        $finish;
    end

endmodule
